// ----- hdl/swpr_pkg.sv -----
// ----------------------------------------------------------------------------
// swpr_pkg: shared types and constants of the stop-and-wait packet receiver
// Packet codes, phase and controller encodings, the controller to datapath
// command and status structs, and the reply byte generator.
// ----------------------------------------------------------------------------
package swpr_pkg;

  localparam int MAX_PACKET_DEF = 64;

  // Packet type and reply codes.
  localparam logic [7:0] TYPE_OPEN   = 8'h01;
  localparam logic [7:0] REPLY_OPEN  = 8'h02;
  localparam logic [7:0] TYPE_CLOSE  = 8'h11;
  localparam logic [7:0] REPLY_CLOSE = 8'h12;
  localparam logic [7:0] TYPE_ACK    = 8'h08;
  localparam logic [7:0] TYPE_FIN    = 8'h10;
  localparam logic [7:0] TYPE_SEND   = 8'h20;
  localparam logic [7:0] RETX_SEQ    = 8'h00;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPLY   = 1'b1;

  typedef enum logic [2:0] {
    PH_OPEN1    = 3'd0,
    PH_OPEN3    = 3'd1,
    PH_TRANSFER = 3'd2,
    PH_CLOSE1   = 3'd3,
    PH_CLOSE3   = 3'd4,
    PH_CLOSED   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    RPL_OPEN  = 2'd0,
    RPL_CLOSE = 2'd1,
    RPL_RETX  = 2'd2,
    RPL_ACK   = 2'd3
  } rpl_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_DECIDE  = 3'd1,
    ST_PAY_RD  = 3'd2,
    ST_PAY_OUT = 3'd3,
    ST_REPLY   = 3'd4
  } ctl_state_t;

  typedef struct packed {
    logic       take;
    logic       out_ld;
    logic       out_pay;
    logic       out_last;
    rpl_t       rpl;
    logic [1:0] rstep;
    logic       phase_we;
    phase_t     phase_val;
    logic       seq_inc;
    logic       pidx_clr;
    logic       pidx_inc;
  } cmd_t;

  typedef struct packed {
    phase_t phase;
    logic   hs_open;
    logic   hs_close;
    logic   is_send;
    logic   is_fin;
    logic   good;
    logic   send_bad;
    logic   seq_match;
    logic   pay_done;
    logic   out_free;
  } status_t;

  // Index of the final byte of a reply packet.
  function automatic logic [1:0] reply_final(input rpl_t r);
    logic [1:0] f;
    f = ((r == RPL_ACK) || (r == RPL_RETX)) ? 2'd2 : 2'd1;
    return f;
  endfunction

  // Byte number step of reply packet r; each reply ends in its own checksum.
  function automatic logic [7:0] reply_byte(input rpl_t r, input logic [1:0] step,
                                            input logic [7:0] seq);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] res;
    case (r)
      RPL_OPEN:  begin b0 = REPLY_OPEN;  b1 = 8'h00; end
      RPL_CLOSE: begin b0 = REPLY_CLOSE; b1 = 8'h00; end
      RPL_RETX:  begin b0 = TYPE_SEND;   b1 = RETX_SEQ; end
      default:   begin b0 = TYPE_ACK;    b1 = seq; end
    endcase
    if (step == 2'd0) begin
      res = b0;
    end else if (step == 2'd1) begin
      res = (reply_final(r) == 2'd1) ? ~b0 : b1;
    end else begin
      res = ~(b0 + b1);
    end
    return res;
  endfunction

endpackage

// ----- hdl/stop_and_wait_packet_receiver_unit.sv -----
// Order: each non-final byte is taken while idle; the final byte is followed by a
// decision state, then a store read and a result load per payload byte, one more
// store read ahead of the ACK, and a result load per reply byte; each result load
// waits while the sink has not taken the previous result. Throughput is set by the
// single packet store read port and the one result register shared by payload and replies.
// Reset is synchronous and active high; it clears phase, sequence and byte counters.
// ----------------------------------------------------------------------------
// stop_and_wait_packet_receiver_unit: stop-and-wait packet receiver
// Collects datagram bytes, checks the inverted-sum checksum of each packet,
// runs the open, transfer and close phases, emits in-sequence payload and
// the matching reply packets.
// ----------------------------------------------------------------------------
module stop_and_wait_packet_receiver_unit import swpr_pkg::*; #(
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // Input items: one datagram byte each, rx_last on the final byte.
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       rx_last,
  // Result items: payload bytes for the file or bytes of a reply packet.
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic [2:0] phase_now
);

  // The controller owns the sequencing; the datapath owns every stored value.
  // They talk only through one command struct and one status struct.
  // The packet store is not cleared and needs no clearing pass.
  cmd_t    cmd;
  status_t sts;

  // Bytes are taken only in the idle state. A result still waiting in the
  // output register does not block the next item from being accepted.
  swpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .rx_last  (rx_last),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath stores up to MAX_PACKET bytes of each packet; bytes past
  // that are only summed and mark the packet oversize.
  swpr_dp #(
    .MAX_PACKET (MAX_PACKET)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx_byte),
    .rx_last   (rx_last),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .phase_now (phase_now)
  );

endmodule

// ----- hdl/swpr_ctrl.sv -----
// ----------------------------------------------------------------------------
// swpr_ctrl: receiver controller
// Accepts bytes, judges each finished packet from datapath status and
// sequences the payload and reply results.
// ----------------------------------------------------------------------------
module swpr_ctrl import swpr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    rx_last,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  ctl_state_t state, state_next;
  rpl_t       rpl, rpl_next;
  logic [1:0] rstep, rstep_next;
  logic       fin_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rpl   <= RPL_OPEN;
      rstep <= 2'd0;
    end else begin
      state <= state_next;
      rpl   <= rpl_next;
      rstep <= rstep_next;
    end
  end

  assign fin_step = (rstep == reply_final(rpl));

  always_comb begin
    state_next    = state;
    rpl_next      = rpl;
    rstep_next    = rstep;
    in_ready      = 1'b0;
    cmd.take      = 1'b0;
    cmd.out_ld    = 1'b0;
    cmd.out_pay   = 1'b0;
    cmd.out_last  = 1'b0;
    cmd.rpl       = rpl;
    cmd.rstep     = rstep;
    cmd.phase_we  = 1'b0;
    cmd.phase_val = sts.phase;
    cmd.seq_inc   = 1'b0;
    cmd.pidx_clr  = 1'b0;
    cmd.pidx_inc  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && rx_last) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = ST_IDLE;
        case (sts.phase)
          PH_OPEN1, PH_CLOSE1: begin
            cmd.phase_we = 1'b1;
            if ((sts.phase == PH_OPEN1) ? sts.hs_open : sts.hs_close) begin
              cmd.phase_val = phase_t'(sts.phase + 3'd1);
              rpl_next      = (sts.phase == PH_OPEN1) ? RPL_OPEN : RPL_CLOSE;
              rstep_next    = 2'd0;
              state_next    = ST_REPLY;
            end else begin
              cmd.phase_val = phase_t'(sts.phase + 3'd2);
            end
          end
          PH_OPEN3, PH_CLOSE3: begin
            cmd.phase_we  = 1'b1;
            cmd.phase_val = phase_t'(sts.phase + 3'd1);
          end
          PH_TRANSFER: begin
            if (sts.is_send) begin
              if (sts.send_bad) begin
                rpl_next   = RPL_RETX;
                rstep_next = 2'd0;
                state_next = ST_REPLY;
              end else if (sts.seq_match) begin
                rpl_next     = RPL_ACK;
                cmd.pidx_clr = 1'b1;
                state_next   = ST_PAY_RD;
              end
            end else if (sts.is_fin) begin
              if (sts.good) begin
                cmd.phase_we  = 1'b1;
                cmd.phase_val = PH_CLOSE1;
              end
            end else begin
              // An unknown packet type ends the transfer.
              cmd.phase_we  = 1'b1;
              cmd.phase_val = PH_CLOSE1;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_PAY_RD: begin
        if (sts.pay_done) begin
          rstep_next = 2'd0;
          state_next = ST_REPLY;
        end else begin
          state_next = ST_PAY_OUT;
        end
      end
      ST_PAY_OUT: begin
        if (sts.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_pay  = 1'b1;
          cmd.pidx_inc = 1'b1;
          state_next   = ST_PAY_RD;
        end
      end
      ST_REPLY: begin
        if (sts.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_last = fin_step;
          if (fin_step) begin
            cmd.seq_inc = (rpl == RPL_ACK);
            state_next  = ST_IDLE;
          end else begin
            rstep_next = rstep + 2'd1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/swpr_dp.sv -----
// ----------------------------------------------------------------------------
// swpr_dp: receiver datapath
// Packet store, byte count, running checksum, header capture, packet
// verdict, phase and sequence registers and the result register.
// ----------------------------------------------------------------------------
module swpr_dp import swpr_pkg::*; #(
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       rx_last,
  input  cmd_t       cmd,
  output status_t    sts,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic [2:0] phase_now
);

  localparam int AW = $clog2(MAX_PACKET);
  localparam int CW = $clog2(MAX_PACKET + 1);

  logic [7:0]    mem [MAX_PACKET];
  logic [7:0]    rdata;
  logic [AW-1:0] rd_addr;

  logic [CW-1:0] byte_count;
  logic [7:0]    running_sum;
  logic          oversize;
  logic [7:0]    hdr0, hdr1, hdr2;
  logic [CW-1:0] cnt_q;
  logic          good_q, ovr_q;
  phase_t        phase;
  logic [7:0]    expected_seq;
  logic [AW-1:0] pidx;

  logic          room;
  logic [CW-1:0] avail;
  logic [7:0]    avail8;
  logic [AW-1:0] pay_len;

  assign room    = (byte_count < CW'(MAX_PACKET));
  assign rd_addr = AW'(3) + pidx;

  always_ff @(posedge clk) begin
    if (cmd.take && room) begin
      mem[byte_count[AW-1:0]] <= rx_byte;
    end
    rdata <= mem[rd_addr];
  end

  // Byte collection and verdict of the finished packet.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_sum <= '0;
      oversize    <= 1'b0;
    end else if (cmd.take) begin
      if (rx_last) begin
        byte_count  <= '0;
        running_sum <= '0;
        oversize    <= 1'b0;
      end else begin
        byte_count  <= room ? byte_count + CW'(1) : byte_count;
        running_sum <= running_sum + rx_byte;
        oversize    <= oversize | ~room;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (byte_count == CW'(0)) hdr0 <= rx_byte;
      if (byte_count == CW'(1)) hdr1 <= rx_byte;
      if (byte_count == CW'(2)) hdr2 <= rx_byte;
      if (rx_last) begin
        cnt_q  <= room ? byte_count + CW'(1) : byte_count;
        ovr_q  <= oversize | ~room;
        good_q <= (~running_sum == rx_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_OPEN1;
      expected_seq <= 8'h00;
      pidx         <= '0;
    end else begin
      if (cmd.phase_we) phase <= cmd.phase_val;
      if (cmd.seq_inc) expected_seq <= expected_seq + 8'h01;
      if (cmd.pidx_clr) begin
        pidx <= '0;
      end else if (cmd.pidx_inc) begin
        pidx <= pidx + AW'(1);
      end
    end
  end

  // Payload length, clamped to the bytes between the length byte and checksum.
  assign avail   = cnt_q - CW'(4);
  assign avail8  = 8'(avail);
  assign pay_len = (hdr2 > avail8) ? AW'(avail) : AW'(hdr2);

  always_comb begin
    sts.phase     = phase;
    sts.hs_open   = !ovr_q && (cnt_q == CW'(2)) && good_q && (hdr0 == TYPE_OPEN);
    sts.hs_close  = !ovr_q && (cnt_q == CW'(2)) && good_q && (hdr0 == TYPE_CLOSE);
    sts.is_send   = (hdr0 == TYPE_SEND);
    sts.is_fin    = (hdr0 == TYPE_FIN);
    sts.good      = good_q;
    sts.send_bad  = ovr_q || (cnt_q < CW'(4)) || !good_q;
    sts.seq_match = (hdr1 == expected_seq);
    sts.pay_done  = (pidx == pay_len);
    sts.out_free  = !out_valid || out_ready;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_kind  <= cmd.out_pay ? KIND_PAYLOAD : KIND_REPLY;
      out_byte  <= cmd.out_pay ? rdata : reply_byte(cmd.rpl, cmd.rstep, expected_seq);
      out_last  <= cmd.out_last;
      phase_now <= phase;
    end
  end

endmodule
